// ===== hw/rtl/lle_pkg.sv =====
// ----------------------------------------------------------------------------
// lle_pkg
// Shared types, sizes and codes for the indexed linked-list engine.
// ----------------------------------------------------------------------------
package lle_pkg;

  localparam int CAPACITY  = 256;
  localparam int WORD_BITS = 32;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam int KIND_W    = 3;
  localparam int POS_W     = 9;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int LEN_W     = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_GET    = 3'd3,
    KIND_SIZE   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_GET_RD,
    S_INS_LINK,
    S_INS_FIX,
    S_REM_HEAD,
    S_REM_SLOT,
    S_REM_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] word_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   word_out;
    logic [LEN_W-1:0]    length;
  } rsp_t;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
    ring_next = (p == SLOT_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/lle_ram.sv =====
// ----------------------------------------------------------------------------
// lle_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lle_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/indexed_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// Ordered list of data words in a linked slot store with a circular free ring.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | beat
//  in_     | in  | in_valid / in_ready    | req_t: kind, position, word_in
//  out_    | out | out_valid / out_ready  | rsp_t: status, word_out, length
//
// one request at a time. size, rejected and end-of-list requests skip the
// walk; an indexed request walks the link RAM one slot per cycle, so its
// time grows with its index. the link-RAM read loop sets that pace. reset is
// synchronous and needs no clearing pass: the free ring reads as identity
// until its entries are written.
// a result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine
  import lle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  state_t state_r, state_nxt;

  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [DATA_W-1:0]   word_r, word_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0]   word_out_r, word_out_nxt;
  logic [CNT_W-1:0]    steps_r, steps_nxt;
  logic                first_r, first_nxt;
  logic [SLOT_W-1:0]   prev_r, prev_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;

  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [SLOT_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SLOT_W-1:0]   frd_r, frd_nxt;
  logic [SLOT_W-1:0]   fwr_r, fwr_nxt;
  logic                fwrap_r, fwrap_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsp_t                out_data_r, out_data_nxt;

  // memory ports
  logic                 l_we, l_re;
  logic [SLOT_W-1:0]    l_wa, l_wd, l_ra, l_rd;
  logic                 w_we, w_re;
  logic [SLOT_W-1:0]    w_wa, w_ra;
  logic [WORD_BITS-1:0] w_wd, w_rd;
  logic                 f_we, f_re;
  logic [SLOT_W-1:0]    f_wa, f_wd, f_ra, f_rd;

  logic [SLOT_W-1:0]    walk_cur;
  logic [SLOT_W-1:0]    free_slot;
  logic [POS_W-1:0]     ins_pos;
  logic                 ring_written;

  lle_ram #(.DEPTH(CAPACITY), .WIDTH(SLOT_W)) u_link (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd),
    .re(l_re), .raddr(l_ra), .rdata(l_rd)
  );

  lle_ram #(.DEPTH(CAPACITY), .WIDTH(WORD_BITS)) u_word (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd),
    .re(w_re), .raddr(w_ra), .rdata(w_rd)
  );

  lle_ram #(.DEPTH(CAPACITY), .WIDTH(SLOT_W)) u_free (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd),
    .re(f_re), .raddr(f_ra), .rdata(f_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // first walk step starts at head, later steps follow the link just read
  assign walk_cur = first_r ? head_r : l_rd;

  // ring entries below the write pointer (or all, once it wrapped) were written
  assign ring_written = fwrap_r || (frd_r < fwr_r);
  assign free_slot    = ring_written ? f_rd : frd_r;

  assign ins_pos = (kind_t'(kind_r) == KIND_APPEND) ? POS_W'(count_r) : pos_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    status_nxt    = status_r;
    word_out_nxt  = word_out_r;
    steps_nxt     = steps_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    slot_nxt      = slot_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    frd_nxt       = frd_r;
    fwr_nxt       = fwr_r;
    fwrap_nxt     = fwrap_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    l_we = 1'b0; l_wa = '0; l_wd = '0; l_re = 1'b0; l_ra = '0;
    w_we = 1'b0; w_wa = '0; w_wd = '0; w_re = 1'b0; w_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_re = 1'b0; f_ra = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_data.kind;
          pos_nxt   = in_data.position;
          word_nxt  = in_data.word_in;
          // fetch the next free slot in case this is an insert
          f_re      = 1'b1;
          f_ra      = frd_r;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        status_nxt   = ST_OK;
        word_out_nxt = '0;
        state_nxt    = S_DONE;
        case (kind_t'(kind_r))
          KIND_INSERT, KIND_APPEND: begin
            if (ins_pos > POS_W'(count_r)) begin
              status_nxt = ST_BAD_INDEX;
            end else if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              frd_nxt  = ring_next(frd_r);
              slot_nxt = free_slot;
              if (ins_pos == '0) begin
                w_we      = 1'b1;
                w_wa      = free_slot;
                w_wd      = WORD_BITS'(word_r);
                l_we      = 1'b1;
                l_wa      = free_slot;
                l_wd      = head_r;
                head_nxt  = free_slot;
                if (count_r == '0) begin
                  tail_nxt = free_slot;
                end
                count_nxt = count_r + 1'b1;
              end else if (ins_pos == POS_W'(count_r)) begin
                w_we      = 1'b1;
                w_wa      = free_slot;
                w_wd      = WORD_BITS'(word_r);
                l_we      = 1'b1;
                l_wa      = tail_r;
                l_wd      = free_slot;
                tail_nxt  = free_slot;
                count_nxt = count_r + 1'b1;
              end else begin
                steps_nxt = CNT_W'(ins_pos - 1'b1);
                first_nxt = 1'b1;
                state_nxt = S_WALK;
              end
            end
          end
          KIND_REMOVE: begin
            if (pos_r >= POS_W'(count_r)) begin
              status_nxt = ST_BAD_INDEX;
            end else if (pos_r == '0) begin
              l_re      = 1'b1;
              l_ra      = head_r;
              state_nxt = S_REM_HEAD;
            end else begin
              steps_nxt = CNT_W'(pos_r - 1'b1);
              first_nxt = 1'b1;
              state_nxt = S_WALK;
            end
          end
          KIND_GET: begin
            if (pos_r >= POS_W'(count_r)) begin
              status_nxt = ST_BAD_INDEX;
            end else begin
              steps_nxt = CNT_W'(pos_r);
              first_nxt = 1'b1;
              state_nxt = S_WALK;
            end
          end
          default: begin
          end
        endcase
      end

      S_WALK: begin
        first_nxt = 1'b0;
        if (steps_r == '0) begin
          prev_nxt = walk_cur;
          case (kind_t'(kind_r))
            KIND_GET: begin
              w_re      = 1'b1;
              w_ra      = walk_cur;
              state_nxt = S_GET_RD;
            end
            KIND_REMOVE: begin
              l_re      = 1'b1;
              l_ra      = walk_cur;
              state_nxt = S_REM_SLOT;
            end
            default: begin
              l_re      = 1'b1;
              l_ra      = walk_cur;
              state_nxt = S_INS_LINK;
            end
          endcase
        end else begin
          l_re      = 1'b1;
          l_ra      = walk_cur;
          steps_nxt = steps_r - 1'b1;
        end
      end

      S_GET_RD: begin
        word_out_nxt = DATA_W'(w_rd);
        state_nxt    = S_DONE;
      end

      S_INS_LINK: begin
        // new slot takes over the successor of prev
        l_we      = 1'b1;
        l_wa      = slot_r;
        l_wd      = l_rd;
        w_we      = 1'b1;
        w_wa      = slot_r;
        w_wd      = WORD_BITS'(word_r);
        state_nxt = S_INS_FIX;
      end

      S_INS_FIX: begin
        l_we = 1'b1;
        l_wa = prev_r;
        l_wd = slot_r;
        if (prev_r == tail_r) begin
          tail_nxt = slot_r;
        end
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end

      S_REM_HEAD: begin
        head_nxt = l_rd;
        if (head_r == tail_r) begin
          tail_nxt = l_rd;
        end
        f_we      = 1'b1;
        f_wa      = fwr_r;
        f_wd      = head_r;
        fwr_nxt   = ring_next(fwr_r);
        if (fwr_r == SLOT_W'(CAPACITY - 1)) begin
          fwrap_nxt = 1'b1;
        end
        count_nxt = count_r - 1'b1;
        state_nxt = S_DONE;
      end

      S_REM_SLOT: begin
        slot_nxt  = l_rd;
        l_re      = 1'b1;
        l_ra      = l_rd;
        state_nxt = S_REM_NEXT;
      end

      S_REM_NEXT: begin
        // unlink: prev skips over the removed slot
        l_we = 1'b1;
        l_wa = prev_r;
        l_wd = l_rd;
        if (slot_r == tail_r) begin
          tail_nxt = prev_r;
        end
        f_we      = 1'b1;
        f_wa      = fwr_r;
        f_wd      = slot_r;
        fwr_nxt   = ring_next(fwr_r);
        if (fwr_r == SLOT_W'(CAPACITY - 1)) begin
          fwrap_nxt = 1'b1;
        end
        count_nxt = count_r - 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = status_r;
          out_data_nxt.word_out = word_out_r;
          out_data_nxt.length   = LEN_W'(count_r);
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      frd_r       <= '0;
      fwr_r       <= '0;
      fwrap_r     <= 1'b0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      frd_r       <= frd_nxt;
      fwr_r       <= fwr_nxt;
      fwrap_r     <= fwrap_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      steps_r     <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    pos_r      <= pos_nxt;
    word_r     <= word_nxt;
    status_r   <= status_nxt;
    word_out_r <= word_out_nxt;
    prev_r     <= prev_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed linked-list engine.
// Requests go in through a queue-fed driver. A monitor keeps its own ordered
// word list, works out the response for every accepted request and compares
// it with the returned beats in order. Coverage includes the empty list, a
// full store, indexes past the end, spare request kinds and random traffic.
// Both handshakes are throttled at random in several phases.
// ----------------------------------------------------------------------------
module tb
  import lle_pkg::*;
;

  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int MAX_REPORTS = 10;
  localparam int POS_MAX     = (1 << POS_W) - 1;
  localparam int DRAIN_WAIT  = 300;

  // request kinds past size; the engine treats them as size
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  req_t in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  req_t              pending_req[$];
  rsp_t              expected_rsp[$];
  logic [DATA_W-1:0] list_words[$];

  logic in_took = 1'b0;
  int   queued_count   = 0;
  int   accepted_count = 0;
  int   result_count   = 0;
  int   mismatches     = 0;
  int   cycle_count    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  rsp_t want_rsp;

  indexed_linked_list_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // list behavior: only element order matters, slots and links are invisible
  function automatic rsp_t list_apply(req_t r);
    rsp_t        rsp;
    int unsigned n;
    int unsigned pos;
    rsp = '0;
    rsp.status = ST_OK;
    n = list_words.size();
    case (r.kind)
      KIND_INSERT, KIND_APPEND: begin
        pos = (r.kind == KIND_APPEND) ? n : int'(r.position);
        if (pos > n) begin
          rsp.status = ST_BAD_INDEX;
        end else if (n >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          list_words.insert(pos, r.word_in);
        end
      end
      KIND_REMOVE: begin
        if (r.position >= n) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          list_words.delete(r.position);
        end
      end
      KIND_GET: begin
        if (r.position >= n) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          rsp.word_out = list_words[r.position];
        end
      end
      default: ;
    endcase
    rsp.length = LEN_W'(list_words.size());
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // driver: new beat only when the line is free or the last beat was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_req.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rsp.push_back(list_apply(in_data));
        accepted_count++;
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing outstanding", result_count));
        end else begin
          want_rsp = expected_rsp.pop_front();
          if (out_data.status !== want_rsp.status || out_data.word_out !== want_rsp.word_out ||
              out_data.length !== want_rsp.length) begin
            report_mismatch($sformatf(
              "result %0d: want status %0d word %h length %0d, got status %0d word %h length %0d",
              result_count, want_rsp.status, want_rsp.word_out, want_rsp.length,
              out_data.status, out_data.word_out, out_data.length));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_req(input logic [KIND_W-1:0] kind, input int pos,
                          input logic [DATA_W-1:0] word);
    req_t r;
    r.kind     = kind;
    r.position = POS_W'(pos);
    r.word_in  = word;
    pending_req.push_back(r);
    queued_count++;
  endtask

  task automatic wait_accepted();
    while (accepted_count != queued_count) @(negedge clk);
  endtask

  task automatic wait_quiet();
    while (accepted_count != queued_count || expected_rsp.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return $urandom;
  endfunction

  // top is the highest in-range index, negative when there is none
  function automatic int pick_position(input int top);
    if (top < 0 || $urandom_range(99) < 12) return $urandom_range(POS_MAX);
    if ($urandom_range(4) == 0) return top;
    if ($urandom_range(3) == 0) return $urandom_range(top < 3 ? top : 3);
    return $urandom_range(top);
  endfunction

  task automatic random_items(input int count);
    int c;
    int roll;
    for (int i = 0; i < count; i++) begin
      // refresh the list length every few beats so most indexes land in range
      if (i % 6 == 0) wait_accepted();
      c = list_words.size();
      roll = $urandom_range(99);
      if (roll < 25) begin
        push_req(KIND_APPEND, $urandom_range(POS_MAX), pick_word());
      end else if (roll < 45) begin
        push_req(KIND_INSERT, pick_position(c), pick_word());
      end else if (roll < 65) begin
        push_req(KIND_REMOVE, pick_position(c - 1), pick_word());
      end else if (roll < 90) begin
        push_req(KIND_GET, pick_position(c - 1), pick_word());
      end else if (roll < 95) begin
        push_req(KIND_SIZE, $urandom_range(POS_MAX), pick_word());
      end else begin
        push_req(KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)),
                 $urandom_range(POS_MAX), pick_word());
      end
    end
  endtask

  // fill the store, poke it while full, then empty it at random indexes
  task automatic fill_and_drain();
    int c;
    wait_quiet();
    c = list_words.size();
    for (int i = c; i < CAPACITY; i++) push_req(KIND_APPEND, $urandom_range(POS_MAX), pick_word());
    wait_quiet();
    push_req(KIND_INSERT, 0, pick_word());
    push_req(KIND_INSERT, CAPACITY + 1, pick_word());
    push_req(KIND_INSERT, CAPACITY, pick_word());
    push_req(KIND_APPEND, 0, pick_word());
    push_req(KIND_GET, CAPACITY - 1, 0);
    push_req(KIND_GET, CAPACITY, 0);
    push_req(KIND_REMOVE, CAPACITY, 0);
    push_req(KIND_REMOVE, CAPACITY - 1, 0);
    push_req(KIND_APPEND, 0, pick_word());
    push_req(KIND_REMOVE, 0, 0);
    push_req(KIND_INSERT, CAPACITY / 2, pick_word());
    push_req(KIND_SIZE, 0, 0);
    wait_quiet();
    c = list_words.size();
    for (int i = 0; i < c; i++) push_req(KIND_REMOVE, $urandom_range(c - 1 - i), 0);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty list corners
    push_req(KIND_SIZE, 0, 0);
    push_req(KIND_GET, 0, 0);
    push_req(KIND_REMOVE, 0, 0);
    push_req(KIND_INSERT, 1, '1);
    // build a short list through every insert path
    push_req(KIND_INSERT, 0, '1);
    push_req(KIND_APPEND, POS_MAX, '0);
    push_req(KIND_INSERT, 2, 32'ha5a5_a5a5);
    push_req(KIND_INSERT, 1, 32'h5a5a_5a5a);
    for (int i = 0; i < 4; i++) push_req(KIND_GET, i, 0);
    push_req(KIND_GET, 4, 0);
    push_req(KIND_GET, POS_MAX, '1);
    push_req(KIND_REMOVE, POS_MAX, 0);
    push_req(KIND_INSERT, CAPACITY, '1);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) push_req(KIND_W'(k), POS_MAX, '1);
    // middle, tail, then head removal
    push_req(KIND_REMOVE, 1, 0);
    push_req(KIND_REMOVE, 2, 0);
    push_req(KIND_REMOVE, 0, 0);
    push_req(KIND_GET, 0, 0);
    push_req(KIND_REMOVE, 0, 0);
    push_req(KIND_SIZE, 0, 0);
    wait_quiet();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      random_items(130);
      if (phase == 2) fill_and_drain();
      // sender holds off until every response is back
      wait_quiet();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lle_pkg.sv
hw/rtl/lle_ram.sv
hw/rtl/indexed_linked_list_engine.sv
tb/tb.sv
